>>> src/sfrs_pkg.sv
`default_nettype none
package sfrs_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int OUTQ_DEPTH    = 4;
    localparam int WORD_W        = 16;

    localparam logic [WORD_W-1:0] SYNC_RESET = 16'h5AA5;
    localparam logic [WORD_W-1:0] CMD_WRITE  = 16'h0001;
    localparam logic [WORD_W-1:0] CMD_READ   = 16'h0002;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BIT   = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic       mosi_bit;
    } sfrs_in_t;

    typedef struct packed {
        logic miso_bit;
        logic frame_error;
        logic in_frame;
    } sfrs_out_t;

    // result of one item, before the stored word from the read is merged in
    typedef struct packed {
        logic valid;
        logic miso_from_mem;
        logic miso_bit;
        logic frame_error;
        logic in_frame;
    } sfrs_stage_t;

endpackage
`default_nettype wire

>>> src/sfrs_ram.sv
`default_nettype none
module sfrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> src/sfrs_frame_ctrl.sv
`default_nettype none
module sfrs_frame_ctrl #(
    parameter int DEPTH = sfrs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_accept,
    input  wire sfrs_pkg::sfrs_in_t            in_data,
    input  wire logic                          cfg_write,
    input  wire logic [sfrs_pkg::WORD_W-1:0]   cfg_data,
    output logic                               mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]           mem_wr_addr,
    output logic [sfrs_pkg::WORD_W-1:0]        mem_wr_data,
    output logic                               mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]           mem_rd_addr,
    input  wire logic [sfrs_pkg::WORD_W-1:0]   mem_rd_data,
    output sfrs_pkg::sfrs_stage_t              stage_out
);
    import sfrs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 2);
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_M   = (AW + 1)'(DEPTH);
    localparam logic [WORD_W:0] DEPTH_W = (WORD_W + 1)'(DEPTH);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SYNC  = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_ADDR  = 3'd4;
    localparam logic [2:0] PH_WDATA = 3'd5;
    localparam logic [2:0] PH_RDATA = 3'd6;
    localparam logic [2:0] PH_ERR   = 3'd7;

    logic [WORD_W-1:0] sync_reg, sync_next;
    logic [WORD_W-1:0] rx_reg, rx_next;
    logic [3:0]        bc_reg, bc_next;
    logic [2:0]        phase_reg, phase_next;
    logic              cmd_wr_reg, cmd_wr_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     done_reg, done_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     rmod_reg, rmod_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] tx_reg, tx_next;
    logic              pend_reg, pend_next;
    sfrs_stage_t       stage_reg, stage_next;

    logic [WORD_W-1:0] eff_tx, eff_sum, rx_new;
    logic [3:0]        bc_inc;
    logic [AW:0]       rm_sum;
    logic [AW-1:0]     rm_new;
    logic              do_load;

    assign sync_next = cfg_write ? cfg_data : sync_reg;

    always_comb begin
        // a word fetched last cycle lands in tx and the checksum now
        eff_tx  = pend_reg ? mem_rd_data : tx_reg;
        eff_sum = pend_reg ? sum_reg + mem_rd_data : sum_reg;
        rx_new  = {rx_reg[WORD_W-2:0], in_data.mosi_bit};
        bc_inc  = bc_reg + 4'd1;
        // address taken modulo DEPTH one bit at a time as it shifts in
        rm_sum  = {((bc_reg == 4'd0) ? '0 : rmod_reg), in_data.mosi_bit};
        rm_new  = (rm_sum >= DEPTH_M) ? AW'(rm_sum - DEPTH_M) : rm_sum[AW-1:0];

        rx_next     = rx_reg;
        bc_next     = bc_reg;
        phase_next  = phase_reg;
        cmd_wr_next = cmd_wr_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        addr_next   = addr_reg;
        rmod_next   = rmod_reg;
        sum_next    = eff_sum;
        tx_next     = eff_tx;
        pend_next   = 1'b0;
        do_load     = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = rx_new;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_reg;

        if (in_accept) begin
            case (in_data.mode)
                MODE_START: begin
                    rx_next     = '0;
                    bc_next     = '0;
                    phase_next  = PH_SYNC;
                    cmd_wr_next = 1'b0;
                    total_next  = '0;
                    done_next   = '0;
                    addr_next   = '0;
                    sum_next    = '0;
                    tx_next     = '0;
                end
                MODE_END: begin
                    phase_next = PH_IDLE;
                    bc_next    = '0;
                end
                MODE_BIT: begin
                    if (phase_reg inside {PH_SYNC, PH_CMD, PH_LEN, PH_ADDR, PH_WDATA}) begin
                        rx_next   = rx_new;
                        bc_next   = bc_inc;
                        rmod_next = rm_new;
                        if (bc_inc == 4'd0) begin
                            case (phase_reg)
                                PH_SYNC: begin
                                    if (rx_new != sync_reg) begin
                                        phase_next = PH_ERR;
                                    end else begin
                                        sum_next   = rx_new;
                                        phase_next = PH_CMD;
                                    end
                                end
                                PH_CMD: begin
                                    if (rx_new != CMD_WRITE && rx_new != CMD_READ) begin
                                        phase_next = PH_ERR;
                                    end else begin
                                        cmd_wr_next = (rx_new == CMD_WRITE);
                                        sum_next    = eff_sum + rx_new;
                                        phase_next  = PH_LEN;
                                    end
                                end
                                PH_LEN: begin
                                    if ({1'b0, rx_new} > DEPTH_W) begin
                                        phase_next = PH_ERR;
                                    end else begin
                                        total_next = CW'(rx_new);
                                        sum_next   = eff_sum + rx_new;
                                        phase_next = PH_ADDR;
                                    end
                                end
                                PH_ADDR: begin
                                    addr_next = rm_new;
                                    sum_next  = eff_sum + rx_new;
                                    done_next = '0;
                                    if (cmd_wr_reg) begin
                                        phase_next = PH_WDATA;
                                    end else begin
                                        phase_next = PH_RDATA;
                                        do_load    = 1'b1;
                                    end
                                end
                                PH_WDATA: begin
                                    if (done_reg < total_reg) begin
                                        mem_wr_en = 1'b1;
                                        sum_next  = eff_sum + rx_new;
                                        addr_next = (addr_reg == ADDR_LAST) ? '0
                                                                            : addr_reg + 1'b1;
                                        done_next = done_reg + 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end else if (phase_reg == PH_RDATA) begin
                        tx_next = {eff_tx[WORD_W-2:0], 1'b0};
                        bc_next = bc_inc;
                        if (bc_inc == 4'd0) begin
                            if (done_reg <= total_reg) begin
                                done_next = done_reg + 1'b1;
                            end
                            do_load = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (do_load) begin
            if (done_next < total_next) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_next;
                pend_next   = 1'b1;
                addr_next   = (addr_next == ADDR_LAST) ? '0 : addr_next + 1'b1;
            end else if (done_next == total_next) begin
                tx_next = sum_next;
            end else begin
                tx_next = '0;
            end
        end

        stage_next.valid         = in_accept;
        stage_next.frame_error   = (phase_next == PH_ERR);
        stage_next.in_frame      = (phase_next != PH_IDLE);
        stage_next.miso_from_mem = (phase_next == PH_RDATA) && pend_next;
        stage_next.miso_bit      = (phase_next == PH_RDATA) && tx_next[WORD_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg   <= SYNC_RESET;
            rx_reg     <= '0;
            bc_reg     <= '0;
            phase_reg  <= PH_IDLE;
            cmd_wr_reg <= 1'b0;
            total_reg  <= '0;
            done_reg   <= '0;
            addr_reg   <= '0;
            rmod_reg   <= '0;
            sum_reg    <= '0;
            tx_reg     <= '0;
            pend_reg   <= 1'b0;
            stage_reg  <= '0;
        end else begin
            sync_reg   <= sync_next;
            rx_reg     <= rx_next;
            bc_reg     <= bc_next;
            phase_reg  <= phase_next;
            cmd_wr_reg <= cmd_wr_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            addr_reg   <= addr_next;
            rmod_reg   <= rmod_next;
            sum_reg    <= sum_next;
            tx_reg     <= tx_next;
            pend_reg   <= pend_next;
            stage_reg  <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule
`default_nettype wire

>>> src/sfrs_out_queue.sv
`default_nettype none
module sfrs_out_queue (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sfrs_pkg::sfrs_stage_t       stage_in,
    input  wire logic [sfrs_pkg::WORD_W-1:0] mem_rd_data,
    output logic                             room,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output sfrs_pkg::sfrs_out_t              m_data
);
    import sfrs_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int NW = $clog2(OUTQ_DEPTH + 1);

    sfrs_out_t       q_mem [OUTQ_DEPTH];
    logic [PW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            push, pop;
    sfrs_out_t       word_in;

    always_comb begin
        word_in.miso_bit    = stage_in.miso_from_mem ? mem_rd_data[WORD_W-1]
                                                     : stage_in.miso_bit;
        word_in.frame_error = stage_in.frame_error;
        word_in.in_frame    = stage_in.in_frame;
    end

    assign push     = stage_in.valid;
    assign pop      = m_valid && m_ready;
    assign wp_next  = push ? wp_reg + 1'b1 : wp_reg;
    assign rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
    assign cnt_next = cnt_reg + NW'(push) - NW'(pop);

    // keep a slot for the word in the stage and one for a new input word
    assign room    = (cnt_reg + NW'(stage_in.valid)) < NW'(OUTQ_DEPTH);
    assign m_valid = (cnt_reg != '0);
    assign m_data  = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= word_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> src/serial_frame_register_slave_unit.sv
// Serial frame register slave: each input word is one event of the host link (chip select
// falls, one clock bit, chip select rises) and yields exactly one result word carrying the
// bit to drive on MISO, the frame error flag and the in-frame flag. One event is taken every
// cycle while the buffer has room; the result word passes through a registered stage before it
// is presented from the buffer, that stage covering the registered read of the word
// store, which holds DEPTH 16-bit entries in one memory with a write port for write frames and
// a read port for read frames. Results pass through that stage into a four-word buffer; with
// the result side stalled, input stops once the stage and the buffer together hold four words.
// The store needs no clearing after reset; only entries written by an earlier frame should be
// read back. The sync word register can be written at any time the block is idle.
`default_nettype none
module serial_frame_register_slave_unit #(
    parameter int DEPTH = sfrs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire sfrs_pkg::sfrs_in_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output sfrs_pkg::sfrs_out_t              m_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sfrs_pkg::WORD_W-1:0] cfg_data
);
    import sfrs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              in_accept;
    logic              room;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    sfrs_stage_t       stage;

    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign in_accept = s_valid && s_ready;

    sfrs_frame_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_data    (s_data),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .mem_wr_en  (wr_en),
        .mem_wr_addr(wr_addr),
        .mem_wr_data(wr_data),
        .mem_rd_en  (rd_en),
        .mem_rd_addr(rd_addr),
        .mem_rd_data(rd_data),
        .stage_out  (stage)
    );

    sfrs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    sfrs_out_queue u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stage_in   (stage),
        .mem_rd_data(rd_data),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

>>> src/sfrs_checker.sv
`default_nettype none
module sfrs_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire sfrs_pkg::sfrs_out_t m_data
);

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    // outside a frame every flag is low
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.in_frame |-> !m_data.frame_error && !m_data.miso_bit)
        else $error("flags set outside a frame");

    // an errored frame never drives data
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_error |-> !m_data.miso_bit)
        else $error("miso driven in errored frame");

endmodule

bind serial_frame_register_slave_unit sfrs_checker u_sfrs_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire

>>> bench/tb_serial_frame_register_slave_unit.sv
`timescale 1ns / 100ps
module tb_serial_frame_register_slave_unit;
    import sfrs_pkg::*;

    localparam int DEPTH           = DEPTH_DEFAULT;
    localparam int NROWS           = 19;
    localparam int WORDS_PER_PHASE = 60;
    localparam int STALL_LIMIT     = 2000;

    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam sfrs_out_t OUT_NONE  = '{miso_bit: 1'b0, frame_error: 1'b0, in_frame: 1'b0};
    localparam sfrs_out_t OUT_ERROR = '{miso_bit: 1'b0, frame_error: 1'b1, in_frame: 1'b1};

    typedef enum logic [2:0] {
        LP_IDLE, LP_SYNC, LP_CMD, LP_LEN, LP_ADDR, LP_WDATA, LP_RDATA, LP_ERR
    } link_phase_e;

    // one frame: chip select falls, header words, body words, loose bits, chip select rises
    typedef struct packed {
        bit          open;
        logic [15:0] sync_w;
        logic [15:0] cmd_w;
        logic [15:0] len_w;
        logic [15:0] addr_w;
        logic [2:0]  hdr_n;
        logic [9:0]  body_n;
        logic [4:0]  tail_n;
        bit          odd3;
        bit          close;
        bit          typed;
        sfrs_out_t   want;
    } frame_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    sfrs_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    sfrs_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    bit          calm = 1'b0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    sfrs_out_t   pending_results [$];
    sfrs_in_t    burst [$];
    frame_row_t  plan [NROWS];

    // slave state as the host sees it
    logic [15:0] sync_reg;
    logic [15:0] rx_sr, tx_sr, csum;
    logic [3:0]  bitpos;
    link_phase_e phase;
    bit          rd_frame;
    int unsigned total_w, done_w;
    logic [7:0]  waddr;
    logic [15:0] store [DEPTH];
    bit          filled [DEPTH];

    serial_frame_register_slave_unit #(.DEPTH(DEPTH)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void open_frame();
        rx_sr    = '0;
        bitpos   = '0;
        phase    = LP_SYNC;
        rd_frame = 1'b0;
        total_w  = 0;
        done_w   = 0;
        waddr    = '0;
        csum     = '0;
        tx_sr    = '0;
    endfunction

    function automatic void fetch_tx();
        if (done_w < total_w) begin
            tx_sr = store[waddr];
            csum  = csum + tx_sr;
            waddr = waddr + 8'd1;
        end else if (done_w == total_w) begin
            tx_sr = csum;
        end else begin
            tx_sr = '0;
        end
    endfunction

    function automatic void take_word(logic [15:0] w);
        case (phase)
            LP_SYNC: begin
                if (w != sync_reg) begin
                    phase = LP_ERR;
                end else begin
                    csum  = w;
                    phase = LP_CMD;
                end
            end
            LP_CMD: begin
                if (w != CMD_WRITE && w != CMD_READ) begin
                    phase = LP_ERR;
                end else begin
                    rd_frame = (w == CMD_READ);
                    csum     = csum + w;
                    phase    = LP_LEN;
                end
            end
            LP_LEN: begin
                if (32'(w) > 32'(DEPTH)) begin
                    phase = LP_ERR;
                end else begin
                    total_w = 32'(w);
                    csum    = csum + w;
                    phase   = LP_ADDR;
                end
            end
            LP_ADDR: begin
                waddr  = w[7:0];
                csum   = csum + w;
                done_w = 0;
                if (!rd_frame) begin
                    phase = LP_WDATA;
                end else begin
                    phase = LP_RDATA;
                    fetch_tx();
                end
            end
            LP_WDATA: begin
                if (done_w < total_w) begin
                    store[waddr]  = w;
                    filled[waddr] = 1'b1;
                    csum          = csum + w;
                    waddr         = waddr + 8'd1;
                    done_w        = done_w + 1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic sfrs_out_t link_step(sfrs_in_t it);
        sfrs_out_t o;
        case (it.mode)
            MODE_START: open_frame();
            MODE_END: begin
                phase  = LP_IDLE;
                bitpos = '0;
            end
            MODE_BIT: begin
                if (phase >= LP_SYNC && phase <= LP_WDATA) begin
                    rx_sr  = {rx_sr[14:0], it.mosi_bit};
                    bitpos = bitpos + 4'd1;
                    if (bitpos == 4'd0) take_word(rx_sr);
                end else if (phase == LP_RDATA) begin
                    tx_sr  = tx_sr << 1;
                    bitpos = bitpos + 4'd1;
                    if (bitpos == 4'd0) begin
                        if (done_w <= total_w) done_w = done_w + 1;
                        fetch_tx();
                    end
                end
            end
            default: ;
        endcase
        o.miso_bit    = (phase == LP_RDATA) ? tx_sr[15] : 1'b0;
        o.frame_error = (phase == LP_ERR);
        o.in_frame    = (phase != LP_IDLE);
        return o;
    endfunction

    // true if this bit would make the slave fetch a store entry nobody wrote
    function automatic bit reads_blank(sfrs_in_t it);
        int unsigned next_done;
        if (it.mode != MODE_BIT || bitpos != 4'd15) return 1'b0;
        if (phase == LP_ADDR) return rd_frame && total_w > 0 && !filled[{rx_sr[6:0], it.mosi_bit}];
        if (phase == LP_RDATA) begin
            next_done = (done_w <= total_w) ? done_w + 1 : done_w;
            return next_done < total_w && !filled[waddr];
        end
        return 1'b0;
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    function automatic void add_item(logic [1:0] m, logic b);
        burst.push_back('{mode: m, mosi_bit: b});
    endfunction

    function automatic void add_word(logic [15:0] w);
        for (int i = 15; i >= 0; i--) add_item(MODE_BIT, w[i]);
    endfunction

    function automatic void stage_frame(frame_row_t r);
        logic [15:0] hdr [4];
        hdr[0] = r.sync_w;
        hdr[1] = r.cmd_w;
        hdr[2] = r.len_w;
        hdr[3] = r.addr_w;
        if (r.open) add_item(MODE_START, 1'($urandom_range(1)));
        for (int i = 0; i < int'(r.hdr_n) && i < 4; i++) add_word(hdr[i]);
        if (r.odd3) add_item(MODE_NOP, 1'($urandom_range(1)));
        for (int i = 0; i < int'(r.body_n); i++) add_word(16'($urandom_range(65535)));
        for (int i = 0; i < int'(r.tail_n); i++) add_item(MODE_BIT, 1'($urandom_range(1)));
        if (r.close) add_item(MODE_END, 1'($urandom_range(1)));
    endfunction

    function automatic frame_row_t pick_frame(logic [15:0] sync_now);
        frame_row_t  f;
        int          pick;
        int          len;
        logic [15:0] v;
        f        = '0;
        f.open   = 1'b1;
        f.close  = ($urandom_range(7) != 0);
        f.hdr_n  = 3'd4;
        f.sync_w = sync_now;
        f.addr_w = 16'($urandom_range(65535));
        f.odd3   = ($urandom_range(15) == 0);
        len      = ($urandom_range(11) == 0) ? int'($urandom_range(48)) : int'($urandom_range(6));
        f.len_w  = 16'(len);
        pick     = int'($urandom_range(99));
        if (pick < 40) begin
            f.cmd_w  = CMD_WRITE;
            f.body_n = 10'(len);
            if ($urandom_range(3) == 0) f.body_n = 10'(len + int'($urandom_range(2)));
            if ($urandom_range(9) == 0) f.body_n = 10'($urandom_range(len));
        end else if (pick < 80) begin
            f.cmd_w  = CMD_READ;
            f.body_n = 10'(len + 1);
            if ($urandom_range(3) == 0) f.body_n = 10'($urandom_range(len + 2));
            if ($urandom_range(3) == 0) f.tail_n = 5'($urandom_range(15));
        end else if (pick < 86) begin
            do v = 16'($urandom_range(65535)); while (v == sync_now);
            f.sync_w = v;
            f.cmd_w  = CMD_WRITE;
            f.tail_n = 5'($urandom_range(20));
        end else if (pick < 91) begin
            do begin
                v = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
            end while (v == CMD_WRITE || v == CMD_READ);
            f.cmd_w  = v;
            f.tail_n = 5'($urandom_range(20));
        end else if (pick < 95) begin
            f.cmd_w  = $urandom_range(1) ? CMD_READ : CMD_WRITE;
            f.len_w  = 16'($urandom_range(65535, DEPTH + 1));
            f.tail_n = 5'($urandom_range(20));
        end else begin
            // header cut short, maybe never closed
            f.cmd_w  = $urandom_range(1) ? CMD_READ : CMD_WRITE;
            f.hdr_n  = 3'($urandom_range(3));
            f.tail_n = 5'($urandom_range(15));
            f.close  = 1'($urandom_range(1));
        end
        return f;
    endfunction

    task automatic push_item(sfrs_in_t it, bit typed_en, sfrs_out_t want);
        sfrs_out_t predicted;
        if (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 25);
        end
        if (reads_blank(it)) it = '{mode: MODE_END, mosi_bit: 1'b0};
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = link_step(it);
        pending_results.push_back(typed_en ? want : predicted);
    endtask

    task automatic play_burst(bit typed_en, sfrs_out_t want);
        int n;
        n = burst.size();
        for (int i = 0; i < n; i++) push_item(burst[i], typed_en && i == n - 1, want);
        burst.delete();
    endtask

    task automatic settle();
        add_item(MODE_END, 1'b0);
        play_burst(1'b0, OUT_NONE);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_sync(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sync_reg = v;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 25);
    end

    always @(posedge aclk) begin
        sfrs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result word %b with nothing pending", m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.miso_bit !== want.miso_bit || m_data.frame_error !== want.frame_error
                        || m_data.in_frame !== want.in_frame) begin
                    flag_mismatch($sformatf(
                        "expected miso=%b err=%b frame=%b, got miso=%b err=%b frame=%b",
                        want.miso_bit, want.frame_error, want.in_frame,
                        m_data.miso_bit, m_data.frame_error, m_data.in_frame));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int          fed;
        frame_row_t  f;
        logic [15:0] sync_now;
        int          n;

        // open sync cmd len addr hdr body tail mode3 close typed want
        plan = '{
            '{1'b0, SYNC_RESET, CMD_WRITE, 16'd0, 16'h0000, 3'd0, 10'd0, 5'd1,
              1'b0, 1'b0, 1'b1, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'd4, 16'h0000, 3'd4, 10'd4, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd4, 16'h0000, 3'd4, 10'd6, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            // wraps past the top of the store, two surplus words
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'd3, 16'h01FE, 3'd4, 10'd5, 5'd0,
              1'b1, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd3, 16'hFFFE, 3'd4, 10'd4, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, 16'hA55A, CMD_WRITE, 16'd0, 16'h0000, 3'd1, 10'd0, 5'd0,
              1'b0, 1'b0, 1'b1, OUT_ERROR},
            // restart while the errored frame is still open
            '{1'b1, SYNC_RESET, 16'h0000, 16'd0, 16'h0000, 3'd2, 10'd0, 5'd0,
              1'b0, 1'b0, 1'b1, OUT_ERROR},
            '{1'b1, SYNC_RESET, 16'h0003, 16'd0, 16'h0000, 3'd2, 10'd0, 5'd5,
              1'b0, 1'b0, 1'b1, OUT_ERROR},
            '{1'b1, SYNC_RESET, 16'hFFFF, 16'd0, 16'h0000, 3'd2, 10'd0, 5'd0,
              1'b0, 1'b1, 1'b1, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd257, 16'h0000, 3'd3, 10'd0, 5'd0,
              1'b0, 1'b0, 1'b1, OUT_ERROR},
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'hFFFF, 16'h0000, 3'd3, 10'd0, 5'd0,
              1'b0, 1'b1, 1'b1, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'd0, 16'h0010, 3'd4, 10'd2, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd0, 16'h1234, 3'd4, 10'd2, 5'd3,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b0, SYNC_RESET, CMD_WRITE, 16'd0, 16'h0000, 3'd0, 10'd0, 5'd0,
              1'b1, 1'b0, 1'b1, OUT_NONE},
            // length equal to the store size, frames closed early
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'd256, 16'h0080, 3'd4, 10'd2, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd256, 16'hFF80, 3'd4, 10'd1, 5'd3,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd0, 16'h0000, 3'd2, 10'd0, 5'd7,
              1'b0, 1'b0, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_READ, 16'd1, 16'h00FF, 3'd4, 10'd1, 5'd7,
              1'b0, 1'b1, 1'b0, OUT_NONE},
            '{1'b1, SYNC_RESET, CMD_WRITE, 16'd2, 16'hFFFF, 3'd4, 10'd2, 5'd0,
              1'b0, 1'b1, 1'b0, OUT_NONE}
        };

        sync_reg = SYNC_RESET;
        open_frame();
        phase = LP_IDLE;
        for (int i = 0; i < DEPTH; i++) filled[i] = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NROWS; i++) begin
            stage_frame(plan[i]);
            play_burst(plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: sync_now = 16'h0000;
                1: sync_now = 16'hFFFF;
                4: sync_now = SYNC_RESET;
                default: sync_now = 16'($urandom_range(65535));
            endcase
            write_sync(sync_now);
            calm = (p == 2);
            fed = 0;
            while (fed < WORDS_PER_PHASE) begin
                if ($urandom_range(19) == 0) begin
                    n = int'($urandom_range(20, 1));
                    repeat (n) add_item(2'($urandom_range(3)), 1'($urandom_range(1)));
                end else begin
                    f = pick_frame(sync_now);
                    stage_frame(f);
                    fed = fed + burst.size();
                end
                play_burst(1'b0, OUT_NONE);
            end
        end
        calm = 1'b0;
        settle();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/sfrs_pkg.sv
src/sfrs_ram.sv
src/sfrs_frame_ctrl.sv
src/sfrs_out_queue.sv
src/serial_frame_register_slave_unit.sv
src/sfrs_checker.sv
bench/tb_serial_frame_register_slave_unit.sv
